### sv/kbd_dec_pkg.sv
// Package for the set-1 scan code decoder: modifier flag type, event codes
// and the key translation tables and helper functions.
// No dependencies.
package kbd_dec_pkg;

  localparam int FLAGS_W   = 7;
  localparam int BASE_LEN  = 84;
  localparam int FLAGS_DEPTH = 1;

  localparam logic [7:0] PREFIX_E0   = 8'hE0;
  localparam logic [7:0] KEY_DELETE  = 8'hD3;
  localparam logic [7:0] KEY_T       = 8'h14;
  localparam logic [7:0] KEY_C       = 8'h2E;
  localparam logic [7:0] KEY_Z       = 8'h2C;

  typedef struct packed {
    logic e0;
    logic scroll;
    logic num;
    logic caps;
    logic alt;
    logic ctl;
    logic shift;
  } flags_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_REBOOT    = 3'd1,
    EV_MONITOR   = 3'd2,
    EV_INTERRUPT = 3'd3,
    EV_STOP      = 3'd4
  } key_event_t;

  localparam logic [7:0] PLAIN_TAB [BASE_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E
  };

  localparam logic [7:0] SHIFT_TAB [BASE_LEN] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E
  };

  function automatic flags_t mod_of(input logic [7:0] k);
    flags_t m;
    m = '0;
    case (k)
      8'h1D, 8'h9D: m.ctl   = 1'b1;
      8'h2A, 8'h36: m.shift = 1'b1;
      8'h38, 8'hB8: m.alt   = 1'b1;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic flags_t lock_of(input logic [7:0] k);
    flags_t m;
    m = '0;
    case (k)
      8'h3A: m.caps   = 1'b1;
      8'h45: m.num    = 1'b1;
      8'h46: m.scroll = 1'b1;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] extended_code(input logic [7:0] k);
    logic [7:0] c;
    case (k)
      8'hC7: c = 8'hE0;
      8'h9C: c = 8'h0A;
      8'hB5: c = 8'h2F;
      8'hC8: c = 8'hE2;
      8'hC9: c = 8'hE6;
      8'hCB: c = 8'hE4;
      8'hCD: c = 8'hE5;
      8'hCF: c = 8'hE1;
      8'hD0: c = 8'hE3;
      8'hD1: c = 8'hE7;
      8'hD2: c = 8'hE8;
      8'hD3: c = 8'hE9;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### sv/kbd_dec_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kbd_dec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/kbd_dec_step.sv
// Decode step for one scan byte: updates the modifier flags and translates the key.
// Depends on kbd_dec_pkg.
module kbd_dec_step (
  input  logic [7:0]            scan_byte,
  input  kbd_dec_pkg::flags_t   flags_in,
  output kbd_dec_pkg::flags_t   flags_out,
  output logic [7:0]            char_code,
  output kbd_dec_pkg::key_event_t key_event
);
  import kbd_dec_pkg::*;

  logic [7:0] key;
  logic [7:0] code;
  flags_t     g;

  always_comb begin
    key       = scan_byte;
    g         = flags_in;
    code      = 8'h00;
    flags_out = flags_in;
    char_code = 8'h00;
    key_event = EV_NONE;
    if (scan_byte == PREFIX_E0) begin
      flags_out    = flags_in;
      flags_out.e0 = 1'b1;
    end else if (scan_byte[7]) begin
      key = flags_in.e0 ? scan_byte : {1'b0, scan_byte[6:0]};
      flags_out    = flags_in & ~mod_of(key);
      flags_out.e0 = 1'b0;
    end else begin
      key  = flags_in.e0 ? (scan_byte | 8'h80) : scan_byte;
      g.e0 = 1'b0;
      g    = g | mod_of(key);
      g    = g ^ lock_of(key);
      flags_out = g;
      if (g.ctl) begin
        if (g.alt && key == KEY_DELETE) begin
          key_event = EV_REBOOT;
        end else if (key == KEY_T) begin
          key_event = EV_MONITOR;
        end else if (key == KEY_C) begin
          key_event = EV_INTERRUPT;
        end else if (key == KEY_Z) begin
          key_event = EV_STOP;
        end
      end else begin
        if (!key[7] && key[6:0] < 7'(BASE_LEN)) begin
          code = g.shift ? SHIFT_TAB[key[6:0]] : PLAIN_TAB[key[6:0]];
        end else if (key[7]) begin
          code = extended_code(key);
        end
        if (g.caps) begin
          if (code inside {[8'h61:8'h7A]}) begin
            code = code - 8'h20;
          end else if (code inside {[8'h41:8'h5A]}) begin
            code = code + 8'h20;
          end
        end
        char_code = code;
      end
    end
  end

endmodule

### sv/keyboard_scancode_decoder_core.sv
// Top level of the set-1 keyboard scan code decoder.
// Depends on kbd_dec_pkg, kbd_dec_ram and kbd_dec_step.
//
// The decoder takes one scan byte per transfer and returns exactly one result
// per byte, in order. It sustains one byte per clock cycle while out_ready
// holds; a byte passes the stage-1 register, then the result register. The
// modifier flags live in a one-entry RAM, read when a byte is taken and
// written back when it leaves the decode stage; a write-back that coincides
// with the next read is forwarded from a register, and a flag bit that reset
// clears makes the entry read as zero until its first write. A result register
// separates the two channels, so a new byte is taken while a result waits.
module keyboard_scancode_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_char_valid,
  output logic [7:0] out_char_code,
  output logic [2:0] out_key_event
);
  import kbd_dec_pkg::*;

  logic       in_fire;
  logic       s1_adv;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       written_r, written_nxt;
  logic       s1_init_r;
  logic       fwd_hit_r;
  flags_t     fwd_flags_r;
  logic [FLAGS_W-1:0] ram_rdata;
  flags_t     cur_flags;
  flags_t     new_flags;
  logic [7:0] dec_code;
  key_event_t dec_event;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_code_r;
  key_event_t out_event_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  kbd_dec_ram #(
    .WIDTH (FLAGS_W),
    .DEPTH (FLAGS_DEPTH)
  ) u_flags_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (1'b0),
    .wdata (FLAGS_W'(new_flags)),
    .re    (in_fire),
    .raddr (1'b0),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd_hit_r) begin
      cur_flags = fwd_flags_r;
    end else if (s1_init_r) begin
      cur_flags = flags_t'(ram_rdata);
    end else begin
      cur_flags = '0;
    end
  end

  kbd_dec_step u_step (
    .scan_byte (s1_byte_r),
    .flags_in  (cur_flags),
    .flags_out (new_flags),
    .char_code (dec_code),
    .key_event (dec_event)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    written_nxt = written_r || s1_adv;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      written_r   <= 1'b0;
      out_valid_r <= 1'b0;
      s1_init_r   <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      written_r   <= written_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        s1_init_r <= written_r;
        fwd_hit_r <= s1_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_scan_byte;
    end
    if (s1_adv) begin
      fwd_flags_r <= new_flags;
      out_code_r  <= dec_code;
      out_event_r <= dec_event;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_code  = out_code_r;
  assign out_char_valid = (out_code_r != 8'h00);
  assign out_key_event  = out_event_r;

endmodule
